### rtl/nrc_pkg.sv
// nrc_pkg: shared types and constants for the nonce replay cache.
// No dependencies.
package nrc_pkg;

   localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;

   localparam logic [15:0] TTL_RESET  = 16'd300;
   localparam logic [15:0] SKEW_RESET = 16'd60;

   localparam logic CSR_TTL  = 1'b0;
   localparam logic CSR_SKEW = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_NEW   = 2'd0,
      VERDICT_DUP   = 2'd1,
      VERDICT_RANGE = 2'd2,
      VERDICT_FULL  = 2'd3
   } verdict_type;

   // back part sequencer
   typedef enum logic [3:0] {
      BK_INIT  = 4'd0,
      BK_IDLE  = 4'd1,
      BK_DIV   = 4'd2,
      BK_REM   = 4'd3,
      BK_FIX   = 4'd4,
      BK_READ  = 4'd5,
      BK_EVAL  = 4'd6,
      BK_WRITE = 4'd7,
      BK_DONE  = 4'd8
   } bk_state_type;

   // one FNV-1a byte step
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      fnv_step = (h ^ {24'd0, b}) * FNV_PRIME;
   endfunction

endpackage

### rtl/nrc_front.sv
// nrc_front: range check and byte-serial FNV-1a hash, one byte per cycle.
// Depends on nrc_pkg. Feeds a classified item into the queue.
module nrc_front import nrc_pkg::*; #(
   parameter int ID_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] ttl,
   input  logic [15:0] skew,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] in_sender,
   input  logic [63:0] in_nonce,
   input  logic [63:0] in_msg_time,
   input  logic [63:0] in_now_time,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [63:0] out_sender,
   output logic [63:0] out_nonce,
   output logic [63:0] out_msg_time,
   output logic [63:0] out_now_time,
   output logic [31:0] out_hash,
   output logic        out_range_bad
);
   localparam int NBYTES = ID_BYTES + 8;
   localparam int CW = $clog2(NBYTES + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [127:0]  bytes_ff, bytes_in;
   logic [31:0]   hash_ff, hash_in;
   logic [63:0]   sender_ff, nonce_ff, mt_ff, now_ff;
   logic          bad_ff;
   logic [63:0]   smask, lo, hi;
   logic          take;

   always_comb begin
      smask = (ID_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * ID_BYTES)) - 64'd1);
   end

   assign in_ready = !busy_ff && !done_ff;
   assign take     = in_valid && in_ready;
   assign lo       = in_now_time - {48'd0, ttl};
   assign hi       = in_now_time + {48'd0, skew};

   // hash sequencer
   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      hash_in  = hash_ff;
      if (take) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         hash_in  = FNV_BASIS;
         bytes_in = (ID_BYTES >= 8) ? {in_nonce, in_sender} :
                    ({in_nonce, 64'd0} >> (64 - 8 * ID_BYTES)) |
                    {64'd0, in_sender & smask};
      end else if (busy_ff) begin
         hash_in  = fnv_step(hash_ff, bytes_ff[7:0]);
         bytes_in = bytes_ff >> 8;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NBYTES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && out_ready) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bytes_ff <= bytes_in;
      hash_ff  <= hash_in;
      if (take) begin
         sender_ff <= in_sender & smask;
         nonce_ff  <= in_nonce;
         mt_ff     <= in_msg_time;
         now_ff    <= in_now_time;
         bad_ff    <= (in_msg_time < lo) || (in_msg_time > hi);
      end
   end

   assign out_valid     = done_ff;
   assign out_sender    = sender_ff;
   assign out_nonce     = nonce_ff;
   assign out_msg_time  = mt_ff;
   assign out_now_time  = now_ff;
   assign out_hash      = hash_ff;
   assign out_range_bad = bad_ff;
endmodule

### rtl/nrc_queue.sv
// nrc_queue: two-entry queue between the front and back parts.
// Depends on nrc_pkg (width only by convention).
module nrc_queue import nrc_pkg::*; #(
   parameter int W = 289
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

### rtl/nrc_back.sv
// nrc_back: bucket select, read, expiry, match and insert; each way is read, then evaluated.
// Depends on nrc_pkg. Holds the entry memory, valid bit stored with each entry.
module nrc_back import nrc_pkg::*; #(
   parameter int BUCKETS = 512,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] ttl,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] in_sender,
   input  logic [63:0] in_nonce,
   input  logic [63:0] in_msg_time,
   input  logic [63:0] in_now_time,
   input  logic [31:0] in_hash,
   input  logic        in_range_bad,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_reject,
   output logic [1:0]  out_verdict
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int EN = BUCKETS * WAYS;
   localparam int EW = $clog2(EN);
   // floor(2^32 / BUCKETS): quotient estimate is exact or one short
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
   localparam logic [31:0] NB    = 32'(BUCKETS);

   logic [192:0]  mem [EN];
   logic [192:0]  rd_ff;
   bk_state_type  st_ff, st_in;
   logic [EW-1:0] clr_ff, clr_in;
   logic [WW-1:0] way_ff, way_in;
   logic [WW:0]   free_ff, free_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [31:0]   h_ff;
   logic [31:0]   quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [63:0]   s_ff, n_ff, mt_ff, now_ff;
   logic          dup_ff, dup_in;
   logic          rv_ff, rv_in;
   logic [1:0]    vd_ff, vd_in;
   logic [63:0]   prod;
   logic [EW-1:0] ra, wa, mem_wa;
   logic [192:0]  mem_wd;
   logic          mem_we;
   logic          take, exp_hit, live, m_hit;
   logic [WW-1:0] fway;

   assign in_ready    = st_ff == BK_IDLE;
   assign take        = in_valid && in_ready;
   assign out_valid   = st_ff == BK_DONE;
   assign out_reject  = rv_ff;
   assign out_verdict = vd_ff;
   assign fway        = free_ff[WW-1:0];
   assign prod        = 64'(h_ff) * 64'(RECIP);

   always_comb begin
      ra = EW'(32'(bkt_ff) * 32'(WAYS) + 32'(way_ff));
      wa = EW'(32'(bkt_ff) * 32'(WAYS) + 32'(fway));
   end

   // age and match of the way just read
   assign exp_hit = rd_ff[192] && ((now_ff - rd_ff[191:128]) >= {48'd0, ttl});
   assign live    = rd_ff[192] && !exp_hit;
   assign m_hit   = live && rd_ff[63:0] == s_ff && rd_ff[127:64] == n_ff;

   always_comb begin
      st_in   = st_ff;
      clr_in  = clr_ff;
      way_in  = way_ff;
      free_in = free_ff;
      bkt_in  = bkt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dup_in  = dup_ff;
      rv_in   = rv_ff;
      vd_in   = vd_ff;
      mem_we  = 1'b0;
      mem_wa  = ra;
      mem_wd  = {1'b0, rd_ff[191:0]};
      case (st_ff)
         // clearing pass after reset, one entry per cycle
         BK_INIT: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == EW'(EN - 1)) st_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (in_valid) begin
               way_in  = '0;
               free_in = {1'b1, {WW{1'b0}}};
               dup_in  = 1'b0;
               if (in_range_bad) begin
                  rv_in = 1'b1;
                  vd_in = VERDICT_RANGE;
                  st_in = BK_DONE;
               end else begin
                  st_in = BK_DIV;
               end
            end
         end
         // hash modulo bucket count: reciprocal estimate, remainder, one fix-up
         BK_DIV: begin
            quo_in = prod[63:32];
            st_in  = BK_REM;
         end
         BK_REM: begin
            rem_in = h_ff - quo_ff * NB;
            st_in  = BK_FIX;
         end
         BK_FIX: begin
            bkt_in = BW'((rem_ff >= NB) ? (rem_ff - NB) : rem_ff);
            st_in  = BK_READ;
         end
         BK_READ: st_in = BK_EVAL;
         // every way is visited so all expired entries get cleared
         BK_EVAL: begin
            mem_we = exp_hit;
            dup_in = dup_ff || m_hit;
            if (!live && free_ff[WW])
               free_in = {1'b0, way_ff};
            if (way_ff == WW'(WAYS - 1)) begin
               if (dup_ff || m_hit) begin
                  rv_in = 1'b1;
                  vd_in = VERDICT_DUP;
                  st_in = BK_DONE;
               end else if (!live || !free_ff[WW]) begin
                  rv_in = 1'b0;
                  vd_in = VERDICT_NEW;
                  st_in = BK_WRITE;
               end else begin
                  rv_in = 1'b0;
                  vd_in = VERDICT_FULL;
                  st_in = BK_DONE;
               end
            end else begin
               way_in = way_ff + 1'b1;
               st_in  = BK_READ;
            end
         end
         // record into the lowest free way
         BK_WRITE: begin
            mem_we = 1'b1;
            mem_wa = wa;
            mem_wd = {1'b1, mt_ff, n_ff, s_ff};
            st_in  = BK_DONE;
         end
         BK_DONE: if (out_ready) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= BK_INIT;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
      end
      way_ff  <= way_in;
      free_ff <= free_in;
      bkt_ff  <= bkt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dup_ff  <= dup_in;
      rv_ff   <= rv_in;
      vd_ff   <= vd_in;
      if (take) begin
         h_ff   <= in_hash;
         s_ff   <= in_sender;
         n_ff   <= in_nonce;
         mt_ff  <= in_msg_time;
         now_ff <= in_now_time;
      end
   end

   // entry memory: one read port, one write port
   always_ff @(posedge clock) begin
      if (st_ff == BK_READ) rd_ff <= mem[ra];
      if (mem_we) mem[mem_wa] <= mem_wd;
   end
endmodule

### rtl/nonce_replay_cache_unit.sv
// nonce_replay_cache_unit: top level of the nonce replay cache.
// Depends on nrc_pkg, nrc_front, nrc_queue, nrc_back.
//
//   channel | direction | beat contents
//   req_    | in        | source_id, nonce, msg_time, now_time
//   rsp_    | out       | reject, verdict
//   csr_    | in        | write enable, index, 16-bit data
//
// Front hashes one byte per cycle and takes no new req_ beat until its item has entered the queue.
// Back: IDLE, DIV, REM, FIX, then READ and EVAL for each way, WRITE when it records, DONE;
// a range reject goes from IDLE straight to DONE. It takes one item at a time.
// After reset the back clears one entry per cycle, all BUCKETS * WAYS, before its first beat.
// Stall on rsp_ready holds the back part; the front keeps filling the queue until it is full.
module nonce_replay_cache_unit import nrc_pkg::*; #(
   parameter int BUCKETS  = 512,
   parameter int WAYS     = 4,
   parameter int ID_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_source_id,
   input  logic [63:0] req_nonce,
   input  logic [63:0] req_msg_time,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reject,
   output logic [1:0]  rsp_verdict,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   logic [15:0] ttl_ff, skew_ff;
   logic        f_valid, f_ready, f_bad, q_valid, q_ready;
   logic [63:0] f_s, f_n, f_mt, f_now;
   logic [31:0] f_h;
   logic [288:0] q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff  <= TTL_RESET;
         skew_ff <= SKEW_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TTL)  ttl_ff  <= csr_wdata;
         if (csr_index == CSR_SKEW) skew_ff <= csr_wdata;
      end
   end

   nrc_front #(.ID_BYTES(ID_BYTES)) u_front (
      .clock, .reset, .ttl(ttl_ff), .skew(skew_ff),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_sender(req_source_id), .in_nonce(req_nonce),
      .in_msg_time(req_msg_time), .in_now_time(req_now_time),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_sender(f_s), .out_nonce(f_n), .out_msg_time(f_mt),
      .out_now_time(f_now), .out_hash(f_h), .out_range_bad(f_bad)
   );

   nrc_queue #(.W(289)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_bad, f_h, f_now, f_mt, f_n, f_s}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   nrc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock, .reset, .ttl(ttl_ff),
      .in_valid(q_valid), .in_ready(q_ready),
      .in_sender(q_data[63:0]), .in_nonce(q_data[127:64]),
      .in_msg_time(q_data[191:128]), .in_now_time(q_data[255:192]),
      .in_hash(q_data[287:256]), .in_range_bad(q_data[288]),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_reject(rsp_reject), .out_verdict(rsp_verdict)
   );
endmodule

### bench/testbench.sv
// testbench: self-checking bench for nonce_replay_cache_unit.
// Depends on nrc_pkg and the RTL of the unit; predicts verdicts from a local cache model.
`timescale 1ns / 1ps

module testbench;
   import nrc_pkg::*;

   localparam int BUCKETS  = 512;
   localparam int WAYS     = 4;
   localparam int ID_BYTES = 8;
   localparam int ENTRIES  = BUCKETS * WAYS;

   typedef struct packed {
      logic [63:0] source_id;
      logic [63:0] nonce;
      logic [63:0] msg_time;
      logic [63:0] now_time;
   } message_type;

   typedef struct packed {
      logic        reject;
      verdict_type verdict;
   } verdict_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_source_id;
   logic [63:0] req_nonce;
   logic [63:0] req_msg_time;
   logic [63:0] req_now_time;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_reject;
   logic [1:0]  rsp_verdict;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   nonce_replay_cache_unit #(
      .BUCKETS(BUCKETS), .WAYS(WAYS), .ID_BYTES(ID_BYTES)
   ) DUT (.*);

   // predictor state
   logic [15:0] ttl_shadow;
   logic [15:0] skew_shadow;
   bit          cache_valid [ENTRIES];
   logic [63:0] cache_sender [ENTRIES];
   logic [63:0] cache_nonce [ENTRIES];
   logic [63:0] cache_stamp [ENTRIES];

   message_type      pending_msgs[$];
   verdict_beat_type expected_verdicts[$];
   int  error_count = 0;
   int  verdict_count = 0;
   int  verdict_hist [4] = '{0, 0, 0, 0};
   bit  hold_off = 0;
   int  sent_count = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // FNV-1a over sender bytes then nonce bytes, low byte first
   function automatic logic [31:0] replay_hash(logic [63:0] sender, logic [63:0] nonce);
      logic [31:0] h;
      h = 32'h811c9dc5;
      for (int i = 0; i < ID_BYTES; i++) begin
         h = h ^ {24'd0, sender[8*i +: 8]};
         h = h * 32'h01000193;
      end
      for (int i = 0; i < 8; i++) begin
         h = h ^ {24'd0, nonce[8*i +: 8]};
         h = h * 32'h01000193;
      end
      return h;
   endfunction

   // computes the verdict for one message and updates the cache copy
   function automatic verdict_beat_type predict_verdict(message_type m);
      verdict_beat_type r;
      logic [63:0] sender, low_bound, high_bound;
      int base, free_way;
      sender = (ID_BYTES >= 8) ? m.source_id : (m.source_id & ((64'd1 << (8*ID_BYTES)) - 1));
      low_bound  = m.now_time - {48'd0, ttl_shadow};
      high_bound = m.now_time + {48'd0, skew_shadow};
      if (m.msg_time < low_bound || m.msg_time > high_bound) begin
         r.reject = 1'b1;
         r.verdict = VERDICT_RANGE;
         return r;
      end
      base = int'(replay_hash(sender, m.nonce) % BUCKETS) * WAYS;
      for (int w = 0; w < WAYS; w++)
         if (cache_valid[base+w] && (m.now_time - cache_stamp[base+w]) >= {48'd0, ttl_shadow})
            cache_valid[base+w] = 0;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (cache_valid[base+w]) begin
            if (cache_sender[base+w] == sender && cache_nonce[base+w] == m.nonce) begin
               r.reject = 1'b1;
               r.verdict = VERDICT_DUP;
               return r;
            end
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      if (free_way < 0) begin
         r.reject = 1'b0;
         r.verdict = VERDICT_FULL;
         return r;
      end
      cache_valid[base+free_way]  = 1;
      cache_sender[base+free_way] = sender;
      cache_nonce[base+free_way]  = m.nonce;
      cache_stamp[base+free_way]  = m.msg_time;
      r.reject = 1'b0;
      r.verdict = VERDICT_NEW;
      return r;
   endfunction

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // driver: offers queued messages, random gaps between beats
   int  send_gap = 0;
   bit  gaps_on = 1;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
         // hold the beat
      end else begin
         if (req_valid && req_ready) begin
            expected_verdicts.push_back(predict_verdict(
               {req_source_id, req_nonce, req_msg_time, req_now_time}));
            sent_count++;
         end
         if (send_gap > 0) begin
            req_valid <= 0;
            send_gap  <= send_gap - 1;
         end else if (pending_msgs.size() > 0) begin
            message_type m;
            m = pending_msgs.pop_front();
            req_valid     <= 1;
            req_source_id <= m.source_id;
            req_nonce     <= m.nonce;
            req_msg_time  <= m.msg_time;
            req_now_time  <= m.now_time;
            send_gap      <= gaps_on ? short_or_long_gap() : 0;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor: random stalls on the result side, compares each beat
   int  stall_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdict_count++;
            if (expected_verdicts.size() == 0) begin
               $error("verdict beat with nothing expected: reject=%0d verdict=%0d",
                      rsp_reject, rsp_verdict);
               error_count++;
            end else begin
               verdict_beat_type e;
               e = expected_verdicts.pop_front();
               verdict_hist[e.verdict]++;
               if (rsp_reject !== e.reject) begin
                  $error("reject: expected %0d, got %0d", e.reject, rsp_reject);
                  error_count++;
               end
               if (rsp_verdict !== e.verdict) begin
                  $error("verdict: expected %0d, got %0d", e.verdict, rsp_verdict);
                  error_count++;
               end
            end
         end
         if (hold_off) begin
            rsp_ready <= 0;
         end else if (stall_gap > 0) begin
            rsp_ready <= 0;
            stall_gap <= stall_gap - 1;
         end else begin
            rsp_ready <= 1;
            stall_gap <= gaps_on ? short_or_long_gap() : 0;
         end
      end
   end

   task automatic write_csr(logic index, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      if (index == CSR_TTL) ttl_shadow = value;
      else skew_shadow = value;
   endtask

   task automatic drain();
      wait (pending_msgs.size() == 0 && !req_valid && expected_verdicts.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic message_type make_msg(logic [63:0] s, logic [63:0] n,
                                            logic [63:0] t, logic [63:0] now);
      message_type m;
      m.source_id = s; m.nonce = n; m.msg_time = t; m.now_time = now;
      return m;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random phase: mostly in-range messages on a small id space so duplicates,
   // expiry and full buckets occur; some wrapped times and out-of-range noise
   task automatic queue_random(int count, logic [63:0] clock_base);
      logic [63:0] now, s, n, t;
      message_type recent[$];
      now = clock_base;
      for (int i = 0; i < count; i++) begin
         now = now + $urandom_range(0, 20);
         case ($urandom_range(0, 9))
            0, 1: begin
               if (recent.size() > 0) begin
                  message_type r;
                  r = recent[$urandom_range(0, recent.size() - 1)];
                  s = r.source_id; n = r.nonce;
               end else begin
                  s = rand64(); n = rand64();
               end
            end
            2: begin s = rand64(); n = rand64(); end
            default: begin s = $urandom_range(0, 7); n = $urandom_range(0, 31); end
         endcase
         if ($urandom_range(0, 9) == 0)
            t = rand64();
         else
            t = now - $urandom_range(0, ttl_shadow) + $urandom_range(0, skew_shadow);
         if ($urandom_range(0, 19) == 0) begin
            now = rand64();
            t = now + $urandom_range(0, 3) - 1;
         end
         pending_msgs.push_back(make_msg(s, n, t, now));
         recent.push_back(make_msg(s, n, t, now));
         if (recent.size() > 16) void'(recent.pop_front());
      end
   endtask

   initial begin
      reset     = 1;
      req_valid = 0;
      req_source_id = 0; req_nonce = 0; req_msg_time = 0; req_now_time = 0;
      rsp_ready = 0;
      csr_we = 0; csr_index = CSR_TTL; csr_wdata = 0;
      ttl_shadow  = TTL_RESET;
      skew_shadow = SKEW_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         cache_valid[i] = 0;
         cache_sender[i] = 0; cache_nonce[i] = 0; cache_stamp[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: reset settings, edges of the time window, duplicates, wrap
      pending_msgs.push_back(make_msg(64'd1, 64'd1, 64'd1000, 64'd1000));
      pending_msgs.push_back(make_msg(64'd1, 64'd1, 64'd1000, 64'd1000));
      pending_msgs.push_back(make_msg(64'd2, 64'd5, 64'd700, 64'd1000));
      pending_msgs.push_back(make_msg(64'd2, 64'd6, 64'd699, 64'd1000));
      pending_msgs.push_back(make_msg(64'd2, 64'd7, 64'd1060, 64'd1000));
      pending_msgs.push_back(make_msg(64'd2, 64'd8, 64'd1061, 64'd1000));
      pending_msgs.push_back(make_msg('1, '1, '1, '1));
      pending_msgs.push_back(make_msg('1, '1, '1, '1));
      pending_msgs.push_back(make_msg(64'd0, 64'd0, 64'd0, 64'd0));
      pending_msgs.push_back(make_msg(64'd0, 64'd0, 64'd0, 64'd0));
      // now - ttl wraps below zero
      pending_msgs.push_back(make_msg(64'd3, 64'd3, 64'd10, 64'd100));
      // entry stamped in the future, revisited so it is evicted
      pending_msgs.push_back(make_msg(64'd4, 64'd4, 64'd2030, 64'd2000));
      pending_msgs.push_back(make_msg(64'd4, 64'd4, 64'd2010, 64'd2010));
      // entry expires after ttl, then accepted as new
      pending_msgs.push_back(make_msg(64'd1, 64'd1, 64'd1300, 64'd1300));
      // now + skew wraps past the top
      pending_msgs.push_back(make_msg(64'hA5A5_5A5A_0F0F_F0F0, 64'h8000_0000_0000_0001,
                                      64'd5, 64'hFFFF_FFFF_FFFF_FFF0));
      drain();

      // ttl of zero: every visited entry expires
      write_csr(CSR_TTL, 16'd0);
      write_csr(CSR_SKEW, 16'd0);
      pending_msgs.push_back(make_msg(64'd9, 64'd9, 64'd500, 64'd500));
      pending_msgs.push_back(make_msg(64'd9, 64'd9, 64'd500, 64'd500));
      pending_msgs.push_back(make_msg(64'd9, 64'd9, 64'd501, 64'd500));
      drain();

      // maximum window, random traffic
      write_csr(CSR_TTL, 16'hFFFF);
      write_csr(CSR_SKEW, 16'hFFFF);
      queue_random(150, rand64());
      drain();

      // small window so entries churn
      write_csr(CSR_TTL, 16'd1);
      write_csr(CSR_SKEW, 16'd3);
      queue_random(100, 64'd50);
      drain();

      // long receiver hold-off while the sender keeps offering
      write_csr(CSR_TTL, 16'd300);
      write_csr(CSR_SKEW, 16'd60);
      gaps_on = 0;
      hold_off = 1;
      queue_random(40, 64'd100000);
      repeat (300) @(posedge clock);
      hold_off = 0;
      gaps_on = 1;
      drain();

      // moderate window, bulk random
      write_csr(CSR_TTL, 16'd2000);
      write_csr(CSR_SKEW, 16'd100);
      queue_random(300, 64'd1_000_000);
      drain();

      $display("Checked %0d verdicts over %0d messages: new %0d, duplicate %0d,",
               verdict_count, sent_count, verdict_hist[0], verdict_hist[1]);
      $display("out of range %0d, bucket full %0d; five csr settings incl. extremes.",
               verdict_hist[2], verdict_hist[3]);
      if (error_count == 0 && expected_verdicts.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### nonce_replay_cache_unit.f
rtl/nrc_pkg.sv
rtl/nrc_front.sv
rtl/nrc_queue.sv
rtl/nrc_back.sv
rtl/nonce_replay_cache_unit.sv
bench/testbench.sv
